FILE: rtl/cilp_pkg.sv
`timescale 1ns / 1ps

package cilp_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // result queue; must hold two results per item on top of what waits
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    localparam logic [7:0] CNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_item;

    // classified character handed from front to back
    typedef struct packed {
        logic       start;
        logic       is_digit;   // valid hex digit, digit holds its value
        logic [3:0] digit;
        logic       is_zero;
        logic       is_x;
    } t_cls;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  consumed;
        logic [1:0]  radix;
        logic        last;
    } t_res;

endpackage

FILE: rtl/cilp_queue.sv
`timescale 1ns / 1ps

module cilp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_push,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    input  logic             i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/cilp_front.sv
`timescale 1ns / 1ps

module cilp_front #(
    parameter int Q_DEPTH = cilp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cilp_pkg::t_item i_item,
    input  logic            push,
    output logic            full,
    output cilp_pkg::t_cls  o_cls,
    output logic            o_empty,
    input  logic            i_pop
);

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;

    cilp_pkg::t_cls cls;
    logic [7:0]     c;

    assign c = i_item.ch;

    always_comb begin
        cls.start    = i_item.start_req;
        cls.is_zero  = (c == CH_0);
        cls.is_x     = (c == CH_LX) || (c == CH_UX);
        cls.is_digit = 1'b1;
        cls.digit    = '0;
        if (c >= CH_0 && c <= CH_9) begin
            cls.digit = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            cls.digit = 4'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            cls.digit = 4'(c - CH_UA + 8'd10);
        end else begin
            cls.is_digit = 1'b0;
        end
    end

    cilp_queue #(
        .WIDTH ($bits(cilp_pkg::t_cls)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (cls),
        .i_push  (push),
        .o_full  (full),
        .o_data  (o_cls),
        .o_empty (o_empty),
        .i_pop   (i_pop)
    );

endmodule

FILE: rtl/cilp_back.sv
`timescale 1ns / 1ps

module cilp_back #(
    parameter int VALUE_BITS = cilp_pkg::VALUE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cilp_pkg::t_cls  i_cls,
    input  logic            i_cls_empty,
    output logic            o_cls_pop,
    output cilp_pkg::t_res  o_result,
    output logic            empty,
    input  logic            pop
);

    cilp_pkg::t_phase         r_phase, n_phase;
    logic [1:0]               r_radix, n_radix;
    logic [VALUE_BITS-1:0]    r_acc, n_acc;
    logic [7:0]               r_count, n_count;

    cilp_pkg::t_res           r_mem [cilp_pkg::RES_DEPTH];
    logic [cilp_pkg::RES_AW-1:0] r_wr, r_rd;
    logic [cilp_pkg::RES_CW-1:0] r_cnt, n_cnt;

    cilp_pkg::t_res           res_a, res_b;
    logic [1:0]               n_res;
    logic                     fire, do_pop;
    logic                     dig10, dig8, in_base;
    logic [VALUE_BITS-1:0]    acc_x8, acc_scaled, acc_next, digit_ext;
    logic [VALUE_BITS+31:0]   acc_wide;

    function automatic cilp_pkg::t_res mk_res(logic [31:0] v, logic [7:0] n, logic [1:0] rx);
        cilp_pkg::t_res r;
        r.value    = v;
        r.consumed = n;
        r.radix    = rx;
        r.last     = 1'b0;
        return r;
    endfunction

    // room for two results whatever the consumer does this cycle
    assign fire      = !i_cls_empty &&
                       (r_cnt <= cilp_pkg::RES_CW'(cilp_pkg::RES_DEPTH - 2));
    assign o_cls_pop = fire;

    assign dig10 = i_cls.is_digit && (i_cls.digit < 4'd10);
    assign dig8  = i_cls.is_digit && (i_cls.digit < 4'd8);

    always_comb begin
        case (r_radix)
            cilp_pkg::RX_OCT: in_base = dig8;
            cilp_pkg::RX_HEX: in_base = i_cls.is_digit;
            default:          in_base = dig10;
        endcase
    end

    // value * base + digit with shifts: 8x, 16x, 8x + 2x
    assign acc_x8    = r_acc << 3;
    assign digit_ext = VALUE_BITS'(i_cls.digit);
    always_comb begin
        case (r_radix)
            cilp_pkg::RX_OCT: acc_scaled = acc_x8;
            cilp_pkg::RX_HEX: acc_scaled = r_acc << 4;
            default:          acc_scaled = acc_x8 + (r_acc << 1);
        endcase
    end
    assign acc_next = acc_scaled + digit_ext;
    assign acc_wide = {32'd0, r_acc};

    // next state
    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            if (i_cls.start) begin
                if (i_cls.is_zero) begin
                    n_phase = cilp_pkg::PH_ZERO;
                end else if (dig10) begin
                    n_phase = cilp_pkg::PH_DIGITS;
                end else begin
                    n_phase = cilp_pkg::PH_IDLE;
                end
            end else begin
                case (r_phase)
                    cilp_pkg::PH_ZERO: begin
                        n_phase = (i_cls.is_x || dig8) ? cilp_pkg::PH_DIGITS
                                                       : cilp_pkg::PH_IDLE;
                    end
                    cilp_pkg::PH_DIGITS: begin
                        n_phase = in_base ? cilp_pkg::PH_DIGITS : cilp_pkg::PH_IDLE;
                    end
                    default: n_phase = cilp_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // datapath and results
    always_comb begin
        n_radix = r_radix;
        n_acc   = r_acc;
        n_count = r_count;
        res_a   = '0;
        res_b   = '0;
        n_res   = 2'd0;
        if (fire) begin
            if (i_cls.start) begin
                case (r_phase)
                    cilp_pkg::PH_ZERO: begin
                        res_a = mk_res(32'd0, 8'd1, cilp_pkg::RX_DEC);
                        n_res = 2'd1;
                    end
                    cilp_pkg::PH_DIGITS: begin
                        res_a = mk_res(acc_wide[31:0], r_count, r_radix);
                        n_res = 2'd1;
                    end
                    default: ;
                endcase
                n_radix = cilp_pkg::RX_DEC;
                n_acc   = '0;
                n_count = 8'd0;
                if (i_cls.is_zero) begin
                    n_count = 8'd1;
                end else if (dig10) begin
                    n_acc   = digit_ext;
                    n_count = 8'd1;
                end else begin
                    // start on a non-digit reports an empty literal at once
                    if (n_res == 2'd0) begin
                        res_a = mk_res(32'd0, 8'd0, cilp_pkg::RX_DEC);
                    end else begin
                        res_b = mk_res(32'd0, 8'd0, cilp_pkg::RX_DEC);
                    end
                    n_res = n_res + 2'd1;
                end
            end else begin
                case (r_phase)
                    cilp_pkg::PH_ZERO: begin
                        if (i_cls.is_x) begin
                            n_radix = cilp_pkg::RX_HEX;
                            n_acc   = '0;
                            n_count = 8'd2;
                        end else if (dig8) begin
                            n_radix = cilp_pkg::RX_OCT;
                            n_acc   = digit_ext;
                            n_count = 8'd2;
                        end else begin
                            // 0 then 8 or 9 still reports octal
                            res_a   = mk_res(32'd0, 8'd1,
                                             dig10 ? cilp_pkg::RX_OCT : cilp_pkg::RX_DEC);
                            n_res   = 2'd1;
                            n_radix = cilp_pkg::RX_DEC;
                            n_acc   = '0;
                            n_count = 8'd0;
                        end
                    end
                    cilp_pkg::PH_DIGITS: begin
                        if (in_base) begin
                            n_acc = acc_next;
                            if (r_count != cilp_pkg::CNT_MAX) begin
                                n_count = r_count + 8'd1;
                            end
                        end else begin
                            res_a   = mk_res(acc_wide[31:0], r_count, r_radix);
                            n_res   = 2'd1;
                            n_radix = cilp_pkg::RX_DEC;
                            n_acc   = '0;
                            n_count = 8'd0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (n_res == 2'd1) begin
            res_a.last = 1'b1;
        end
        if (n_res == 2'd2) begin
            res_b.last = 1'b1;
        end
    end

    // result queue, up to two writes per cycle
    assign empty    = (r_cnt == '0);
    assign o_result = r_mem[r_rd];
    assign do_pop   = pop && !empty;

    always_comb begin
        n_cnt = r_cnt + cilp_pkg::RES_CW'(n_res);
        if (do_pop) begin
            n_cnt = n_cnt - cilp_pkg::RES_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cilp_pkg::PH_IDLE;
            r_radix <= cilp_pkg::RX_DEC;
            r_acc   <= '0;
            r_count <= 8'd0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_wr    <= r_wr + cilp_pkg::RES_AW'(n_res);
            r_cnt   <= n_cnt;
            if (do_pop) begin
                r_rd <= r_rd + cilp_pkg::RES_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res != 2'd0) begin
            r_mem[r_wr] <= res_a;
        end
        if (n_res == 2'd2) begin
            r_mem[r_wr + cilp_pkg::RES_AW'(1)] <= res_b;
        end
    end

`ifndef NO_ASSERTIONS
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cilp_pkg::RES_CW'(cilp_pkg::RES_DEPTH))
        else $error("result queue overfilled");

    a_digits_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cilp_pkg::PH_DIGITS |-> r_count != 8'd0)
        else $error("open literal with no characters");

    a_hex_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cilp_pkg::PH_DIGITS && r_radix == cilp_pkg::RX_HEX) |-> r_count >= 8'd2)
        else $error("hex literal without prefix count");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !i_cls.start && r_phase == cilp_pkg::PH_DIGITS && !in_base)
        |=> (r_phase == cilp_pkg::PH_IDLE && r_acc == '0))
        else $error("literal end did not clear state");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cilp_pkg::PH_IDLE |-> (r_count == 8'd0 && r_radix == cilp_pkg::RX_DEC))
        else $error("idle with stale literal state");
`endif

endmodule

FILE: rtl/c_integer_literal_parser_top.sv
`timescale 1ns / 1ps

// C integer literal parser (decimal, octal, hex). Characters enter through a
// queue-style port (push/full), one per clock while full is low, and are
// decoded in a front stage into a small queue; the back end tracks the open
// literal and accumulates value * base + digit per character, so the
// sustained rate is one character per cycle while the result queue has room.
// A character that ends a literal yields one result; a start flag on a
// non-digit while a literal is open yields two in the same cycle. Results
// leave through a 4-entry queue (empty/pop); the back end takes a character
// only while that queue has two free slots. A result is written into the
// result queue when the back end takes the character that causes it.
module c_integer_literal_parser_top #(
    parameter int VALUE_BITS = cilp_pkg::VALUE_BITS_DEF,
    parameter int Q_DEPTH    = cilp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cilp_pkg::t_item i_item,
    input  logic            push,
    output logic            full,
    output cilp_pkg::t_res  o_result,
    output logic            empty,
    input  logic            pop
);

    cilp_pkg::t_cls cls;
    logic           cls_empty;
    logic           cls_pop;

    cilp_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .push    (push),
        .full    (full),
        .o_cls   (cls),
        .o_empty (cls_empty),
        .i_pop   (cls_pop)
    );

    cilp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (cls),
        .i_cls_empty (cls_empty),
        .o_cls_pop   (cls_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

FILE: tb/c_integer_literal_parser_top_tb.sv
`timescale 1ns / 1ps

module c_integer_literal_parser_top_tb;

    localparam logic [4:0] NO_DIGIT = 5'd16;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        LIT_DEC,
        LIT_OCT,
        LIT_HEX,
        LIT_ZERO
    } t_lit_form;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    cilp_pkg::t_item i_item  = '0;
    logic            push    = 1'b0;
    logic            full;
    cilp_pkg::t_res  o_result;
    logic            empty;
    logic            pop     = 1'b0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    c_integer_literal_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // value of c as a hex digit, NO_DIGIT if it is none
    function automatic logic [4:0] digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return NO_DIGIT;
    endfunction

    class literal_scoreboard;
        cilp_pkg::t_phase ph;
        logic [1:0]       radix;
        logic [31:0]      acc;
        logic [7:0]       count;
        cilp_pkg::t_res   expected_q[$];
        int unsigned      errors;

        function new();
            clear_literal();
            errors = 0;
        endfunction

        function void clear_literal();
            ph    = cilp_pkg::PH_IDLE;
            radix = cilp_pkg::RX_DEC;
            acc   = '0;
            count = '0;
        endfunction

        function void add_result(logic [31:0] v, logic [7:0] n, logic [1:0] rx);
            expected_q.push_back('{value: v, consumed: n, radix: rx, last: 1'b0});
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // advance the literal state by one accepted character
        function void note_item(cilp_pkg::t_item it);
            logic [4:0]     d;
            int unsigned    base;
            int unsigned    first;
            cilp_pkg::t_res tail;
            first = expected_q.size();
            d     = digit_value(it.ch);
            base  = (radix == cilp_pkg::RX_OCT) ? 8 : (radix == cilp_pkg::RX_HEX) ? 16 : 10;
            if (it.start_req) begin
                // an open literal is closed by the new start
                if (ph == cilp_pkg::PH_ZERO) begin
                    add_result('0, 8'd1, cilp_pkg::RX_DEC);
                end else if (ph == cilp_pkg::PH_DIGITS) begin
                    add_result(acc, count, radix);
                end
                clear_literal();
                if (it.ch == CH_0) begin
                    ph    = cilp_pkg::PH_ZERO;
                    count = 8'd1;
                end else if (d < 10) begin
                    ph    = cilp_pkg::PH_DIGITS;
                    acc   = 32'(d);
                    count = 8'd1;
                end else begin
                    add_result('0, 8'd0, cilp_pkg::RX_DEC);
                end
            end else if (ph == cilp_pkg::PH_ZERO) begin
                if (it.ch == CH_LO_X || it.ch == CH_UP_X) begin
                    radix = cilp_pkg::RX_HEX;
                    acc   = '0;
                    count = 8'd2;
                    ph    = cilp_pkg::PH_DIGITS;
                end else if (d < 8) begin
                    radix = cilp_pkg::RX_OCT;
                    acc   = 32'(d);
                    count = 8'd2;
                    ph    = cilp_pkg::PH_DIGITS;
                end else if (d < 10) begin
                    add_result('0, 8'd1, cilp_pkg::RX_OCT);
                    clear_literal();
                end else begin
                    add_result('0, 8'd1, cilp_pkg::RX_DEC);
                    clear_literal();
                end
            end else if (ph == cilp_pkg::PH_DIGITS) begin
                if (d < base) begin
                    acc = acc * base + 32'(d);
                    if (count != cilp_pkg::CNT_MAX) count++;
                end else begin
                    add_result(acc, count, radix);
                    clear_literal();
                end
            end
            if (expected_q.size() > first) begin
                tail      = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.push_back(tail);
            end
        endfunction

        function void field_mismatch(string name, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        endfunction

        function void check_result(cilp_pkg::t_res got);
            cilp_pkg::t_res want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0d/%0d/%0b",
                         $time, got.value, got.consumed, got.radix, got.last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value) field_mismatch("value", want.value, got.value);
            if (got.consumed !== want.consumed)
                field_mismatch("consumed", 32'(want.consumed), 32'(got.consumed));
            if (got.radix !== want.radix)
                field_mismatch("radix", 32'(want.radix), 32'(got.radix));
            if (got.last !== want.last)
                field_mismatch("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    literal_scoreboard lit_sb = new();

    // transfers are taken at the edge, before the block updates its outputs
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) lit_sb.note_item(i_item);
        if (i_rst_n && pop && !empty) lit_sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // push stays high into the next call, so it is never dropped and raised in one step
    task automatic send_item(input logic [7:0] c, input logic s);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= '{ch: c, start_req: s};
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item("a", 1'b0);
        send_item("1", 1'b1);
        send_item("2", 1'b0);
        send_item("3", 1'b0);
        send_item(" ", 1'b0);
        send_item("0", 1'b1);
        send_item("x", 1'b0);
        send_item("F", 1'b0);
        send_item("f", 1'b0);
        send_item(CH_NUL, 1'b0);
        send_item("0", 1'b1);
        send_item("7", 1'b0);
        send_item(";", 1'b0);
        send_item("0", 1'b1);
        send_item("X", 1'b0);
        send_item("g", 1'b0);
        send_item("0", 1'b1);
        send_item("9", 1'b0);
        send_item(8'hFF, 1'b1);
        send_item("5", 1'b1);
        send_item("0", 1'b1);
        send_item("q", 1'b1);
        send_item("0", 1'b1);
        send_item(".", 1'b0);
    endtask

    // one literal with random content and a random way of ending it
    task automatic send_literal(input int unsigned n_digits, output int unsigned sent);
        t_lit_form   form;
        int unsigned base;
        int unsigned v;
        int unsigned pick;
        logic [7:0]  c;
        form = t_lit_form'($urandom_range(3));
        base = (form == LIT_DEC) ? 10 : (form == LIT_HEX) ? 16 : 8;
        sent = 0;
        if (form == LIT_DEC) begin
            send_item(CH_0 + 8'($urandom_range(1, 9)), 1'b1);
            sent++;
        end else begin
            send_item(CH_0, 1'b1);
            sent++;
            if (form == LIT_HEX) begin
                send_item($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0);
                sent++;
            end
        end
        if (form == LIT_OCT && n_digits == 0) n_digits = 1;
        if (form == LIT_ZERO) n_digits = 0;
        repeat (n_digits) begin
            v = $urandom_range(base - 1);
            if (v < 10) c = CH_0 + 8'(v);
            else c = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
            send_item(c, 1'b0);
            sent++;
        end
        pick = $urandom_range(99);
        if (form == LIT_ZERO && pick < 30) begin
            // octal chosen, then an 8 or 9 ends it
            send_item(CH_8 + 8'($urandom_range(1)), 1'b0);
            sent++;
        end else if (pick < 50) begin
            do begin
                c = 8'($urandom_range(255));
            end while (digit_value(c) < base ||
                       (form == LIT_ZERO && (c == CH_LO_X || c == CH_UP_X)));
            send_item(c, 1'b0);
            sent++;
        end else if (pick < 62) begin
            send_item(CH_NUL, 1'b0);
            sent++;
        end else if (pick < 80) begin
            send_item(8'($urandom_range(255)), 1'b1);
            sent++;
        end
        // otherwise left open for the next start to close
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned done_cnt;
        int unsigned sent;
        int unsigned n;
        logic [7:0]  c;
        logic        s;
        done_cnt = 0;
        while (done_cnt < target) begin
            if ($urandom_range(3) != 0) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(11, 20) : $urandom_range(8);
                send_literal(n, sent);
                done_cnt += sent;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    c = 8'($urandom_range(255));
                    s = ($urandom_range(99) < 30);
                    send_item(c, s);
                    done_cnt++;
                end
            end
        end
    endtask

    initial begin
        int unsigned sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        // long enough to saturate the character count and wrap the value, unless the zero form is drawn
        send_literal($urandom_range(260, 300), sent);
        run_random(110);
        send_idle_pct = 83;
        run_random(110);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        run_random(110);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random(110);
        push <= 1'b0;
        while (lit_sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (lit_sb.errors == 0) begin
            $display("c_integer_literal_parser_top_tb: done, clean");
        end else begin
            $display("c_integer_literal_parser_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("c_integer_literal_parser_top_tb: done, errors");
        $finish;
    end

endmodule
